[sv/chacha20_stream_cipher_defines.svh]
// ---------------------------------------------------------------------------
// ChaCha20 stream cipher assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef CHACHA20_STREAM_CIPHER_DEFINES_SVH
`define CHACHA20_STREAM_CIPHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CC20_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CC20_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/cc20_pkg.sv]
// ---------------------------------------------------------------------------
// ChaCha20 shared package
// Types, register indexes and constants used across the cipher modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cc20_pkg;

    // Block geometry.
    localparam int WORD_W      = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int BYTE_POS_W  = 6;
    localparam int QR_LANES    = 4;
    localparam int ROUND_PAIRS = 10;
    localparam int ROUND_W     = $clog2(2 * ROUND_PAIRS);

    // Block function constants ("expand 32-byte k").
    localparam logic [WORD_W-1:0] SIGMA0 = 32'h61707865;
    localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320646e;
    localparam logic [WORD_W-1:0] SIGMA2 = 32'h79622d32;
    localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b206574;

    // Request queue between the front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KEY_PART0       = 3'd0,
        CFG_KEY_PART1       = 3'd1,
        CFG_KEY_PART2       = 3'd2,
        CFG_KEY_PART3       = 3'd3,
        CFG_NONCE_LOW       = 3'd4,
        CFG_NONCE_HIGH      = 3'd5,
        CFG_INITIAL_COUNTER = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [63:0]       key_part0;
        logic [63:0]       key_part1;
        logic [63:0]       key_part2;
        logic [63:0]       key_part3;
        logic [63:0]       nonce_low;
        logic [31:0]       nonce_high;
        logic [WORD_W-1:0] initial_counter;
    } cfg_t;

    // One queued input request.
    typedef struct packed {
        logic [7:0] plain_byte;
        logic       message_start;
        logic       message_end;
    } item_t;

    typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] word_block_t;

    // Back-to-core control and core-to-back status.
    typedef struct packed {
        logic start;
    } core_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_FINAL
    } core_state_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_WAIT,
        BACK_EMIT
    } back_state_t;

endpackage

[sv/cc20_front.sv]
// ---------------------------------------------------------------------------
// ChaCha20 front end
// Accepts input requests and holds them in a short queue for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chacha20_stream_cipher_defines.svh"

module cc20_front
    import cc20_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  pop,
    output item_t head,
    output logic  head_valid
);

    item_t                  q_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   push;

    // Queue status.
    assign in_ready   = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = q_mem[rd_ptr_reg];
    assign push       = in_valid && in_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

    `CC20_ASSERT_IMPLIES(a_pop_not_empty, pop, count_reg != '0, "pop from an empty queue")

endmodule

[sv/cc20_core.sv]
// ---------------------------------------------------------------------------
// ChaCha20 block core
// Runs twenty rounds as four quarter-round lanes, one add/xor/rotate step
// per cycle, then adds the input block back to form the keystream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chacha20_stream_cipher_defines.svh"

module cc20_core
    import cc20_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  core_ctrl_t  ctrl,
    input  word_block_t block_words,
    output core_stat_t  stat,
    output word_block_t ks_words
);

    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(2 * ROUND_PAIRS - 1);
    localparam logic [1:0]         STEP_LAST  = 2'd3;

    core_state_t        state_reg, state_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [1:0]         step_reg, step_next;
    word_block_t        work_reg, work_next;
    word_block_t        init_reg;
    word_block_t        ks_reg;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int n);
        rotl = (v << n) | (v >> (WORD_W - n));
    endfunction

    assign stat.busy = (state_reg != CORE_IDLE);
    assign stat.done = (state_reg == CORE_FINAL);
    assign ks_words  = ks_reg;

    // Sequencer: load, twenty rounds of four steps, final add.
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        step_next  = step_reg;
        unique case (state_reg)
            CORE_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = CORE_ROUND;
                    round_next = '0;
                    step_next  = '0;
                end
            end
            CORE_ROUND:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == STEP_LAST)
                begin
                    if (round_reg == ROUND_LAST)
                    begin
                        state_next = CORE_FINAL;
                    end
                    else
                    begin
                        round_next = round_reg + ROUND_W'(1);
                    end
                end
            end
            CORE_FINAL:
            begin
                state_next = CORE_IDLE;
            end
            default:
            begin
                state_next = CORE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CORE_IDLE;
            round_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            step_reg  <= step_next;
        end
    end

    // One quarter-round step in all four lanes; odd rounds use the diagonals.
    always_comb
    begin : qr_step
        logic [1:0]        ln;
        logic [1:0]        sh;
        logic [3:0]        ia;
        logic [3:0]        ib;
        logic [3:0]        ic;
        logic [3:0]        id;
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] mix;
        work_next = work_reg;
        sh = round_reg[0] ? 2'd1 : 2'd0;
        for (int lane = 0; lane < QR_LANES; lane++)
        begin
            ln  = 2'(lane);
            ia  = {2'd0, ln};
            ib  = {2'd1, 2'(ln + sh)};
            ic  = {2'd2, 2'(ln + (sh << 1))};
            id  = {2'd3, 2'(ln + sh + (sh << 1))};
            sum = '0;
            mix = '0;
            case (step_reg)
                2'd0:
                begin
                    sum = work_reg[ia] + work_reg[ib];
                    mix = work_reg[id] ^ sum;
                    work_next[ia] = sum;
                    work_next[id] = rotl(mix, 16);
                end
                2'd1:
                begin
                    sum = work_reg[ic] + work_reg[id];
                    mix = work_reg[ib] ^ sum;
                    work_next[ic] = sum;
                    work_next[ib] = rotl(mix, 12);
                end
                2'd2:
                begin
                    sum = work_reg[ia] + work_reg[ib];
                    mix = work_reg[id] ^ sum;
                    work_next[ia] = sum;
                    work_next[id] = rotl(mix, 8);
                end
                default:
                begin
                    sum = work_reg[ic] + work_reg[id];
                    mix = work_reg[ib] ^ sum;
                    work_next[ic] = sum;
                    work_next[ib] = rotl(mix, 7);
                end
            endcase
        end
    end

    // Working state, block input and keystream registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == CORE_IDLE && ctrl.start)
        begin
            init_reg <= block_words;
            work_reg <= block_words;
        end
        else if (state_reg == CORE_ROUND)
        begin
            work_reg <= work_next;
        end
        if (state_reg == CORE_FINAL)
        begin
            for (int i = 0; i < BLOCK_WORDS; i++)
            begin
                ks_reg[i] <= work_reg[i] + init_reg[i];
            end
        end
    end

    `CC20_ASSERT_IMPLIES(a_start_when_idle, ctrl.start, state_reg == CORE_IDLE,
        "block start while the core is busy")
    `CC20_ASSERT_NEXT(a_final_then_idle, state_reg == CORE_FINAL, state_reg == CORE_IDLE,
        "core did not return to idle after the final add")

endmodule

[sv/cc20_back.sv]
// ---------------------------------------------------------------------------
// ChaCha20 back end
// Tracks block counter and byte position, starts a new keystream block when
// one is due, and XORs each queued byte into the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chacha20_stream_cipher_defines.svh"

module cc20_back
    import cc20_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  item_t      head,
    input  logic       head_valid,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] cipher_byte,
    output logic       last_out
);

    back_state_t           state_reg, state_next;
    logic [BYTE_POS_W-1:0] pos_reg, pos_next;
    logic [WORD_W-1:0]     ctr_reg, ctr_next;
    logic                  out_valid_reg;
    logic [7:0]            cipher_byte_reg;
    logic                  last_out_reg;

    logic [BYTE_POS_W-1:0] eff_pos;
    logic [BYTE_POS_W-1:0] sel_pos;
    logic [WORD_W-1:0]     eff_ctr;
    logic [WORD_W-1:0]     ks_word;
    logic [7:0]            ks_byte;
    logic                  out_free;
    logic                  emit;
    core_ctrl_t            core_ctrl;
    core_stat_t            core_stat;
    word_block_t           block_words;
    word_block_t           ks_words;

    cc20_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (core_ctrl),
        .block_words (block_words),
        .stat        (core_stat),
        .ks_words    (ks_words)
    );

    // A message start restarts the counter and the block position.
    assign eff_pos  = head.message_start ? '0 : pos_reg;
    assign eff_ctr  = head.message_start ? cfg.initial_counter : ctr_reg;
    assign sel_pos  = (state_reg == BACK_EMIT) ? '0 : eff_pos;
    assign out_free = !out_valid_reg || out_ready;

    // Keystream byte select, little-endian within each word.
    assign ks_word = ks_words[sel_pos[BYTE_POS_W-1:2]];
    assign ks_byte = ks_word[{sel_pos[1:0], 3'b000} +: 8];

    // Block input: constants, key, counter, nonce.
    always_comb
    begin
        block_words[0]  = SIGMA0;
        block_words[1]  = SIGMA1;
        block_words[2]  = SIGMA2;
        block_words[3]  = SIGMA3;
        block_words[4]  = cfg.key_part0[31:0];
        block_words[5]  = cfg.key_part0[63:32];
        block_words[6]  = cfg.key_part1[31:0];
        block_words[7]  = cfg.key_part1[63:32];
        block_words[8]  = cfg.key_part2[31:0];
        block_words[9]  = cfg.key_part2[63:32];
        block_words[10] = cfg.key_part3[31:0];
        block_words[11] = cfg.key_part3[63:32];
        block_words[12] = eff_ctr;
        block_words[13] = cfg.nonce_low[31:0];
        block_words[14] = cfg.nonce_low[63:32];
        block_words[15] = cfg.nonce_high;
    end

    // Request sequencer.
    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        ctr_next        = ctr_reg;
        pop             = 1'b0;
        emit            = 1'b0;
        core_ctrl.start = 1'b0;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (head_valid)
                begin
                    if (eff_pos == '0)
                    begin
                        core_ctrl.start = 1'b1;
                        ctr_next        = eff_ctr + WORD_W'(1);
                        state_next      = BACK_WAIT;
                    end
                    else if (out_free)
                    begin
                        emit     = 1'b1;
                        pop      = 1'b1;
                        pos_next = sel_pos + BYTE_POS_W'(1);
                    end
                end
            end
            BACK_WAIT:
            begin
                if (core_stat.done)
                begin
                    state_next = BACK_EMIT;
                end
            end
            BACK_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    pop        = 1'b1;
                    pos_next   = sel_pos + BYTE_POS_W'(1);
                    state_next = BACK_IDLE;
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            pos_reg       <= '0;
            ctr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            ctr_reg   <= ctr_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            cipher_byte_reg <= head.plain_byte ^ ks_byte;
            last_out_reg    <= head.message_end;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cipher_byte = cipher_byte_reg;
    assign last_out    = last_out_reg;

    `CC20_ASSERT_IMPLIES(a_launch_core_idle, core_ctrl.start, !core_stat.busy,
        "new block requested while the core is busy")
    `CC20_ASSERT_NEXT(a_done_to_emit, state_reg == BACK_WAIT && core_stat.done,
        state_reg == BACK_EMIT, "finished block not followed by its first byte")
    `CC20_ASSERT_IMPLIES(a_pop_has_item, pop, head_valid, "pop without a queued request")

endmodule

[sv/chacha20_stream_cipher.sv]
// ---------------------------------------------------------------------------
// ChaCha20 stream cipher
// Byte-wide ChaCha20 encrypt/decrypt with a queued front end and a
// quarter-round block core.
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_ready | plain_byte, message_start, message_end
//  out     | output    | out_valid/out_ready | cipher_byte, last_out
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// A byte that needs a new keystream block (block position zero or a message
// start) waits for 80 quarter-round steps in the core (20 rounds of 4 steps,
// four lanes at once), one final add and the handoff. The other 63 bytes of
// a block use the stored keystream without a new core run. Reset clears
// the queue, counters and output valid; no clearing pass. A two-entry queue
// and the output register let the input and output sides stall independently.
`timescale 1ns / 1ps

module chacha20_stream_cipher
    import cc20_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             plain_byte,
    input  logic                   message_start,
    input  logic                   message_end,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             cipher_byte,
    output logic                   last_out,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Register values after reset: all zero except the initial counter.
    localparam cfg_t CFG_RESET_VALUE = '{
        key_part0:       64'd0,
        key_part1:       64'd0,
        key_part2:       64'd0,
        key_part3:       64'd0,
        nonce_low:       64'd0,
        nonce_high:      32'd0,
        initial_counter: 32'd1
    };

    cfg_t  cfg_reg;
    item_t in_item;
    item_t head;
    logic  head_valid;
    logic  pop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET_VALUE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_KEY_PART0:       cfg_reg.key_part0       <= cfg_data;
                CFG_KEY_PART1:       cfg_reg.key_part1       <= cfg_data;
                CFG_KEY_PART2:       cfg_reg.key_part2       <= cfg_data;
                CFG_KEY_PART3:       cfg_reg.key_part3       <= cfg_data;
                CFG_NONCE_LOW:       cfg_reg.nonce_low       <= cfg_data;
                CFG_NONCE_HIGH:      cfg_reg.nonce_high      <= cfg_data[31:0];
                CFG_INITIAL_COUNTER: cfg_reg.initial_counter <= cfg_data[WORD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_item.plain_byte    = plain_byte;
    assign in_item.message_start = message_start;
    assign in_item.message_end   = message_end;

    cc20_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    cc20_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cipher_byte (cipher_byte),
        .last_out    (last_out)
    );

endmodule
